### src/tpb_pkg.sv
// ----------------------------------------------------------------------------
// tpb_pkg
// Shared types, constants and helpers of the triangle band tessellator.
// ----------------------------------------------------------------------------
`default_nettype none

package tpb_pkg;

    // Highest tessellation level after clamping.
    localparam int MAX_LEVEL = 32;
    // Width of a level, a vertex index and a rational term.
    localparam int LW = 6;
    // Width of one Q1.15 coordinate.
    localparam int CW = 16;
    // Q1.15 value of 1.0.
    localparam logic [CW-1:0] FIX_ONE = 16'h8000;

    // Configuration register indexes.
    localparam logic [2:0] REG_OUTER0    = 3'd0;
    localparam logic [2:0] REG_OUTER1    = 3'd1;
    localparam logic [2:0] REG_OUTER2    = 3'd2;
    localparam logic [2:0] REG_INNER     = 3'd3;
    localparam logic [2:0] REG_CLOCKWISE = 3'd4;

    // Side codes.
    localparam logic [1:0] SIDE_0 = 2'd0;
    localparam logic [1:0] SIDE_1 = 2'd1;
    localparam logic [1:0] SIDE_2 = 2'd2;
    localparam logic [1:0] SIDE_3 = 2'd3;

    typedef struct packed {
        logic [1:0] side_index;
        logic [3:0] ring_index;
    } t_in;

    typedef struct packed {
        logic [CW-1:0] first_x;
        logic [CW-1:0] first_y;
        logic [CW-1:0] first_z;
        logic [CW-1:0] second_x;
        logic [CW-1:0] second_y;
        logic [CW-1:0] second_z;
        logic [CW-1:0] third_x;
        logic [CW-1:0] third_y;
        logic [CW-1:0] third_z;
        logic          empty_band;
        logic          last_of_band;
    } t_out;

    // A vertex as two rationals: along-edge pn/pd and depth qn/qd.
    typedef struct packed {
        logic [LW-1:0] pn;
        logic [LW-1:0] pd;
        logic [LW-1:0] qn;
        logic [LW-1:0] qd;
    } t_vtx;

    // One row of vertices: vertex j has pn = base + j.
    typedef struct packed {
        logic [LW-1:0] base;
        logic [LW-1:0] pd;
        logic [LW-1:0] qn;
        logic [LW-1:0] qd;
        logic [LW-1:0] cnt;
    } t_row;

    // One triangle: three vertices and the side that places each one.
    typedef struct packed {
        t_vtx [2:0]       v;
        logic [2:0][1:0]  side;
    } t_trg;

    // Status of the band walker toward the converter.
    typedef struct packed {
        logic tri_valid;
        logic done;
        t_trg trg;
    } t_wstat;

    // Clamp a level register into lo..MAX_LEVEL.
    function automatic logic [LW-1:0] clamp_level(input logic [LW-1:0] v,
                                                  input logic [LW-1:0] lo);
        logic [LW-1:0] res;
        res = v;
        if (v < lo) begin
            res = lo;
        end else if (v > LW'(MAX_LEVEL)) begin
            res = LW'(MAX_LEVEL);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### src/tpb_div.sv
// ----------------------------------------------------------------------------
// tpb_div
// Shared radix-2 divider: quot = floor((n * 65536 + d) / (2 * d)), n <= d.
// ----------------------------------------------------------------------------
`default_nettype none

module tpb_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [tpb_pkg::LW-1:0]    i_num,
    input  wire logic [tpb_pkg::LW-1:0]    i_den,
    output logic                           o_done,
    output logic [tpb_pkg::CW-1:0]         o_quot
);

    logic                      r_busy;
    logic                      r_done;
    logic [3:0]                r_cnt;
    logic [tpb_pkg::LW:0]      r_rem;
    logic [tpb_pkg::LW:0]      r_den2;
    logic [tpb_pkg::CW-1:0]    r_low;
    logic [tpb_pkg::CW-1:0]    r_quot;

    logic [tpb_pkg::LW+1:0]    w_trial;
    logic                      w_ge;
    logic [tpb_pkg::LW+1:0]    w_diff;

    // One quotient bit per cycle: shift in the next bit of the low word.
    assign w_trial = {r_rem, r_low[tpb_pkg::CW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den2};
    assign w_diff  = w_trial - {1'b0, r_den2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath; the high part of the dividend is n, which is below 2d.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den2 <= {i_den, 1'b0};
            r_low  <= {{(tpb_pkg::CW-tpb_pkg::LW){1'b0}}, i_den};
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[tpb_pkg::LW:0] : w_trial[tpb_pkg::LW:0];
            r_low  <= {r_low[tpb_pkg::CW-2:0], 1'b0};
            r_quot <= {r_quot[tpb_pkg::CW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

### src/tpb_walk.sv
// ----------------------------------------------------------------------------
// tpb_walk
// Band walker: steps along the long row and yields one triangle at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module tpb_walk (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic                      i_adv,
    input  wire logic [1:0]                i_side,
    input  wire logic [3:0]                i_ring,
    input  wire logic [tpb_pkg::LW-1:0]    i_ol,
    input  wire logic [tpb_pkg::LW-1:0]    i_lv,
    input  wire logic                      i_cw,
    output tpb_pkg::t_wstat                o_stat
);

    typedef enum logic [3:0] {
        W_IDLE, W_SETUP, W_EVAL_A, W_TRI_A, W_TRI_B,
        W_EVAL_F, W_TRI_F, W_EVAL_C, W_TRI_C, W_DONE
    } t_wstate;

    localparam int LW = tpb_pkg::LW;

    t_wstate           r_state;
    logic [1:0]        r_side;
    logic [3:0]        r_ring;
    logic [LW-1:0]     r_ol;
    logic [LW-1:0]     r_lv;
    logic              r_cw;
    tpb_pkg::t_row     r_long;
    tpb_pkg::t_row     r_short;
    logic              r_order;
    logic              r_centre;
    logic [LW-1:0]     r_i;
    logic [LW-1:0]     r_si;

    tpb_pkg::t_row     w_prev;
    tpb_pkg::t_row     w_cur;
    logic [LW-1:0]     w_ring;
    logic              w_cur_long;
    logic              w_centre;
    tpb_pkg::t_vtx     w_li;
    tpb_pkg::t_vtx     w_li1;
    tpb_pkg::t_vtx     w_ss;
    tpb_pkg::t_vtx     w_ss1;
    tpb_pkg::t_vtx     w_mid;
    logic [2*LW-1:0]   w_lhs;
    logic [2*LW-1:0]   w_rhs;
    logic              w_reach;
    tpb_pkg::t_trg     w_trg;

    function automatic tpb_pkg::t_vtx row_vtx(input tpb_pkg::t_row r,
                                              input logic [LW-1:0] j);
        tpb_pkg::t_vtx v;
        v.pn = r.base + j;
        v.pd = r.pd;
        v.qn = r.qn;
        v.qd = r.qd;
        return v;
    endfunction

    // Rows of the requested band: outer edge or inner ring ring-1, and ring.
    assign w_ring = {2'b00, r_ring};
    always_comb begin
        if (r_ring == 4'd0) begin
            w_prev.base = '0;
            w_prev.pd   = r_ol;
            w_prev.qn   = '0;
            w_prev.qd   = LW'(1);
            w_prev.cnt  = r_ol + LW'(1);
        end else begin
            w_prev.base = w_ring;
            w_prev.pd   = r_lv;
            w_prev.qn   = w_ring;
            w_prev.qd   = r_lv;
            w_prev.cnt  = r_lv - {w_ring[LW-2:0], 1'b0} + LW'(1);
        end
        w_cur.base = w_ring + LW'(1);
        w_cur.pd   = r_lv;
        w_cur.qn   = w_ring + LW'(1);
        w_cur.qd   = r_lv;
        w_cur.cnt  = r_lv - {w_ring[LW-2:0], 1'b0} - LW'(1);
    end

    assign w_cur_long = w_cur.cnt > w_prev.cnt;
    assign w_centre   = (r_side == tpb_pkg::SIDE_2) &&
                        ((w_ring + LW'(1)) == {1'b0, r_lv[LW-1:1]}) &&
                        (w_cur.cnt == LW'(2));

    // Candidate vertices around the walk position.
    assign w_li  = row_vtx(r_long, r_i);
    assign w_li1 = row_vtx(r_long, r_i + LW'(1));
    assign w_ss  = row_vtx(r_short, r_si);
    assign w_ss1 = row_vtx(r_short, r_si + LW'(1));
    // The centre triangle sits on the first vertex of the innermost ring.
    assign w_mid = row_vtx(w_cur, '0);

    // Exact compare of the long and short along-edge parameters.
    assign w_lhs   = w_li.pn * r_short.pd;
    assign w_rhs   = w_ss.pn * r_long.pd;
    assign w_reach = w_lhs >= w_rhs;

    // Triangle presented in each emitting state.
    always_comb begin
        w_trg.side = {r_side, r_side, r_side};
        unique case (r_state)
            W_TRI_A, W_TRI_F: begin
                w_trg.v[0] = w_ss;
                w_trg.v[1] = r_order ? w_li  : w_ss1;
                w_trg.v[2] = r_order ? w_ss1 : w_li;
            end
            W_TRI_C: begin
                w_trg.v[0]    = w_mid;
                w_trg.v[1]    = w_mid;
                w_trg.v[2]    = w_mid;
                w_trg.side[0] = tpb_pkg::SIDE_0;
                w_trg.side[1] = r_cw ? tpb_pkg::SIDE_2 : tpb_pkg::SIDE_1;
                w_trg.side[2] = r_cw ? tpb_pkg::SIDE_1 : tpb_pkg::SIDE_2;
            end
            default: begin
                w_trg.v[0] = w_li;
                w_trg.v[1] = r_order ? w_li1 : w_ss;
                w_trg.v[2] = r_order ? w_ss  : w_li1;
            end
        endcase
    end

    // Sequencer over the band.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
        end else if (i_start) begin
            r_state <= W_SETUP;
            r_side  <= i_side;
            r_ring  <= i_ring;
            r_ol    <= i_ol;
            r_lv    <= i_lv;
            r_cw    <= i_cw;
        end else begin
            unique case (r_state)
                W_IDLE, W_DONE: begin
                    r_state <= r_state;
                end
                W_SETUP: begin
                    r_long   <= w_cur_long ? w_cur : w_prev;
                    r_short  <= w_cur_long ? w_prev : w_cur;
                    r_order  <= w_cur_long ? r_cw : !r_cw;
                    r_centre <= w_centre;
                    r_i      <= '0;
                    r_si     <= '0;
                    r_state  <= W_EVAL_A;
                end
                W_EVAL_A: begin
                    if (w_reach && ((r_si + LW'(1)) < r_short.cnt)) begin
                        r_state <= W_TRI_A;
                    end else begin
                        r_state <= W_TRI_B;
                    end
                end
                W_TRI_A: begin
                    if (i_adv) begin
                        r_si    <= r_si + LW'(1);
                        r_state <= W_TRI_B;
                    end
                end
                W_TRI_B: begin
                    if (i_adv) begin
                        r_i <= r_i + LW'(1);
                        if ((r_i + LW'(1)) == (r_long.cnt - LW'(1))) begin
                            r_state <= W_EVAL_F;
                        end else begin
                            r_state <= W_EVAL_A;
                        end
                    end
                end
                W_EVAL_F: begin
                    if ((r_si + LW'(1)) != r_short.cnt) begin
                        r_state <= W_TRI_F;
                    end else begin
                        r_state <= W_EVAL_C;
                    end
                end
                W_TRI_F: begin
                    if (i_adv) begin
                        r_state <= W_EVAL_C;
                    end
                end
                W_EVAL_C: begin
                    r_state <= r_centre ? W_TRI_C : W_DONE;
                end
                W_TRI_C: begin
                    if (i_adv) begin
                        r_state <= W_DONE;
                    end
                end
                default: begin
                    r_state <= W_IDLE;
                end
            endcase
        end
    end

    assign o_stat.tri_valid = (r_state == W_TRI_A) || (r_state == W_TRI_B) ||
                              (r_state == W_TRI_F) || (r_state == W_TRI_C);
    assign o_stat.done      = r_state == W_DONE;
    assign o_stat.trg       = w_trg;

endmodule

`default_nettype wire

### src/tri_patch_band_tessellator.sv
// ----------------------------------------------------------------------------
// tri_patch_band_tessellator
// Emits the stitched triangles of one band of a triangle-domain patch.
// ----------------------------------------------------------------------------
//  channel | signals                                 | role
//  --------+-----------------------------------------+---------------------------
//  input   | i_valid, o_stall, i_in                  | side and ring of a band
//  output  | o_valid, i_stall, o_out                 | one triangle per item
//  config  | i_cfg_wr_en, i_cfg_index, i_cfg_data    | levels and winding
//
//  Each triangle takes six passes of the shared divider plus the sequencer
//  states around them. An empty band answers in the cycle after it is accepted.
//  Reset is synchronous and active low. The block takes no new item until the
//  last triangle of a band has been taken; a stalled result holds.
// ----------------------------------------------------------------------------
`default_nettype none

module tri_patch_band_tessellator (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire tpb_pkg::t_in      i_in,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output tpb_pkg::t_out          o_out,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [5:0]        i_cfg_data
);

    localparam int LW = tpb_pkg::LW;
    localparam int CW = tpb_pkg::CW;

    typedef enum logic [2:0] {
        S_IDLE, S_FIRST, S_DIV, S_DWAIT, S_ADV, S_SETTLE, S_OUT
    } t_state;

    t_state                 r_state;
    logic [LW-1:0]          r_outer0;
    logic [LW-1:0]          r_outer1;
    logic [LW-1:0]          r_outer2;
    logic [LW-1:0]          r_inner;
    logic                   r_cw;
    logic [1:0]             r_vi;
    logic                   r_isq;
    logic [CW-1:0]          r_b;
    logic [2:0][2:0][CW-1:0] r_coord;
    logic                   r_valid;
    logic                   r_empty;
    logic                   r_last;

    logic [LW-1:0]          w_lv;
    logic [LW-1:0]          w_ol;
    logic                   w_empty;
    logic                   w_start;
    logic                   w_adv;
    logic                   w_div_start;
    tpb_pkg::t_wstat        w_stat;
    tpb_pkg::t_vtx          w_vtx;
    logic [LW-1:0]          w_num;
    logic [LW-1:0]          w_den;
    logic                   w_div_done;
    logic [CW-1:0]          w_quot;
    logic [CW-1:0]          w_a;
    logic [2:0][CW-1:0]     w_perm;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer0 <= LW'(1);
            r_outer1 <= LW'(1);
            r_outer2 <= LW'(1);
            r_inner  <= LW'(2);
            r_cw     <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                tpb_pkg::REG_OUTER0:    r_outer0 <= i_cfg_data;
                tpb_pkg::REG_OUTER1:    r_outer1 <= i_cfg_data;
                tpb_pkg::REG_OUTER2:    r_outer2 <= i_cfg_data;
                tpb_pkg::REG_INNER:     r_inner  <= i_cfg_data;
                tpb_pkg::REG_CLOCKWISE: r_cw     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Request decode: clamped levels and the empty-band check (side 3 or a ring beyond the innermost).
    assign w_lv = tpb_pkg::clamp_level(r_inner, LW'(2));
    always_comb begin
        unique case (i_in.side_index)
            tpb_pkg::SIDE_0: w_ol = tpb_pkg::clamp_level(r_outer0, LW'(1));
            tpb_pkg::SIDE_1: w_ol = tpb_pkg::clamp_level(r_outer1, LW'(1));
            default:         w_ol = tpb_pkg::clamp_level(r_outer2, LW'(1));
        endcase
    end
    assign w_empty = (i_in.side_index == tpb_pkg::SIDE_3) ||
                     ({2'b00, i_in.ring_index} >= {1'b0, w_lv[LW-1:1]});

    assign w_start     = (r_state == S_IDLE) && i_valid && !w_empty;
    assign w_adv       = r_state == S_ADV;
    assign w_div_start = r_state == S_DIV;

    tpb_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_adv   (w_adv),
        .i_side  (i_in.side_index),
        .i_ring  (i_in.ring_index),
        .i_ol    (w_ol),
        .i_lv    (w_lv),
        .i_cw    (r_cw),
        .o_stat  (w_stat)
    );

    // Divider operands: along-edge or depth rational of the current vertex.
    assign w_vtx = w_stat.trg.v[r_vi];
    assign w_num = r_isq ? w_vtx.qn : w_vtx.pn;
    assign w_den = r_isq ? w_vtx.qd : w_vtx.pd;

    tpb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Place (1-p, p, q) on the axes that the vertex's side selects.
    assign w_a = tpb_pkg::FIX_ONE - r_b;
    always_comb begin
        unique case (w_stat.trg.side[r_vi])
            tpb_pkg::SIDE_0: w_perm = {w_a, w_quot, r_b};
            tpb_pkg::SIDE_1: w_perm = {w_quot, r_b, w_a};
            default:         w_perm = {r_b, w_a, w_quot};
        endcase
    end

    // Sequencer: convert each triangle, look ahead for the last, hand over.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_vi    <= '0;
            r_isq   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (w_empty) begin
                            r_coord <= '0;
                            r_empty <= 1'b1;
                            r_last  <= 1'b1;
                            r_valid <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_FIRST;
                        end
                    end
                end
                S_FIRST: begin
                    if (w_stat.tri_valid) begin
                        r_vi    <= '0;
                        r_isq   <= 1'b0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (w_div_done) begin
                        if (!r_isq) begin
                            r_b     <= w_quot;
                            r_isq   <= 1'b1;
                            r_state <= S_DIV;
                        end else begin
                            r_coord[r_vi] <= {w_perm[2], w_perm[1], w_perm[0]};
                            r_isq         <= 1'b0;
                            if (r_vi == 2'd2) begin
                                r_state <= S_ADV;
                            end else begin
                                r_vi    <= r_vi + 2'd1;
                                r_state <= S_DIV;
                            end
                        end
                    end
                end
                S_ADV: begin
                    r_state <= S_SETTLE;
                end
                S_SETTLE: begin
                    if (w_stat.tri_valid || w_stat.done) begin
                        r_empty <= 1'b0;
                        r_last  <= w_stat.done;
                        r_valid <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_valid <= 1'b0;
                        r_vi    <= '0;
                        r_isq   <= 1'b0;
                        r_state <= r_last ? S_IDLE : S_DIV;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall = r_state != S_IDLE;
    assign o_valid = r_valid;

    assign o_out.first_x      = r_coord[0][2];
    assign o_out.first_y      = r_coord[0][1];
    assign o_out.first_z      = r_coord[0][0];
    assign o_out.second_x     = r_coord[1][2];
    assign o_out.second_y     = r_coord[1][1];
    assign o_out.second_z     = r_coord[1][0];
    assign o_out.third_x      = r_coord[2][2];
    assign o_out.third_y      = r_coord[2][1];
    assign o_out.third_z      = r_coord[2][0];
    assign o_out.empty_band   = r_empty;
    assign o_out.last_of_band = r_last;

endmodule

`default_nettype wire

### src/tpb_chk.sv
// ----------------------------------------------------------------------------
// tpb_chk
// Port-level checks of the band tessellator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tpb_chk (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_stall,
    input wire logic          o_valid,
    input wire logic          i_stall,
    input wire tpb_pkg::t_out o_out
);

    // A result waiting to be taken holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("stalled result changed");

    // No new item is taken while a result is still pending.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while result pending");

    // An empty band is a single result; its first x, second y and third z are zero.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.empty_band |-> o_out.last_of_band &&
        o_out.first_x == '0 && o_out.second_y == '0 && o_out.third_z == '0)
        else $error("malformed empty band");

    // After the last item of a band the input side opens again.
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_out.last_of_band |=> !o_stall)
        else $error("input not reopened after last item");

endmodule

bind tri_patch_band_tessellator tpb_chk u_tpb_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_out   (o_out)
);

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the triangle band tessellator. An in-bench
// predictor rebuilds each band's triangles from the current levels and
// compares every result item, field by field, against the queue of expected
// triangles, under several idling and back-pressure phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    // An index past the register list; writes to it must be ignored.
    localparam logic [2:0] REG_UNUSED = 3'd5;

    typedef struct {
        int pn;
        int pd;
        int qn;
        int qd;
    } t_rat_vtx;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_stall;
    tpb_pkg::t_in  i_in = '0;
    logic          o_valid;
    logic          i_stall = 1'b0;
    tpb_pkg::t_out o_out;
    logic          i_cfg_wr_en = 1'b0;
    logic [2:0]    i_cfg_index = '0;
    logic [5:0]    i_cfg_data = '0;

    // Bench copy of the configuration registers.
    int           lvl_outer [3];
    int           lvl_inner;
    bit           wind_cw;

    tpb_pkg::t_out tri_queue[$];
    int           fail_cnt = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_cycles = 0;

    tri_patch_band_tessellator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Q1.15 value of n/d, rounded to nearest with halves up.
    function automatic logic [15:0] fix_of(int n, int d);
        longint num;
        num = longint'(n) * 65536 + d;
        return 16'(num / (2 * longint'(d)));
    endfunction

    // Three coordinates of a vertex placed on the given side.
    function automatic logic [47:0] place_vtx(int side, t_rat_vtx v);
        logic [15:0] a, b, c;
        a = fix_of(v.pd - v.pn, v.pd);
        b = fix_of(v.pn, v.pd);
        c = fix_of(v.qn, v.qd);
        if (side == 0) begin
            return {a, c, b};
        end else if (side == 1) begin
            return {c, b, a};
        end
        return {b, a, c};
    endfunction

    function automatic tpb_pkg::t_out make_tri(int sa, int sb, int sc,
                                               t_rat_vtx a, t_rat_vtx b, t_rat_vtx c);
        tpb_pkg::t_out t;
        t = '0;
        {t.first_x, t.first_y, t.first_z}    = place_vtx(sa, a);
        {t.second_x, t.second_y, t.second_z} = place_vtx(sb, b);
        {t.third_x, t.third_y, t.third_z}    = place_vtx(sc, c);
        return t;
    endfunction

    function automatic t_rat_vtx ring_vtx(int k, int i, int lv);
        t_rat_vtx v;
        v.pn = k + 1 + i;
        v.pd = lv;
        v.qn = k + 1;
        v.qd = lv;
        return v;
    endfunction

    function automatic int clamp_lvl(int v, int lo);
        if (v < lo) return lo;
        if (v > tpb_pkg::MAX_LEVEL) return tpb_pkg::MAX_LEVEL;
        return v;
    endfunction

    // Queue every triangle that one band request should produce.
    function automatic void predict_band(tpb_pkg::t_in req);
        t_rat_vtx prev_row[tpb_pkg::MAX_LEVEL + 1];
        t_rat_vtx cur_row[tpb_pkg::MAX_LEVEL + 1];
        t_rat_vtx lrow[tpb_pkg::MAX_LEVEL + 1];
        t_rat_vtx srow[tpb_pkg::MAX_LEVEL + 1];
        tpb_pkg::t_out band[$];
        tpb_pkg::t_out t;
        int side, ring, lv, ol, n_prev, n_cur, n_long, n_short, n_steps, si;
        bit ord;
        side = int'(req.side_index);
        ring = int'(req.ring_index);
        lv = clamp_lvl(lvl_inner, 2);
        if (side > 2 || ring >= lv / 2) begin
            t = '0;
            t.empty_band = 1'b1;
            t.last_of_band = 1'b1;
            tri_queue.push_back(t);
            return;
        end
        ol = clamp_lvl(lvl_outer[side], 1);
        if (ring == 0) begin
            n_prev = ol + 1;
            for (int i = 0; i < n_prev; i++) begin
                prev_row[i].pn = i;
                prev_row[i].pd = ol;
                prev_row[i].qn = 0;
                prev_row[i].qd = 1;
            end
        end else begin
            n_prev = lv - 2 * (ring - 1) - 1;
            for (int i = 0; i < n_prev; i++) prev_row[i] = ring_vtx(ring - 1, i, lv);
        end
        n_cur = lv - 2 * ring - 1;
        for (int i = 0; i < n_cur; i++) cur_row[i] = ring_vtx(ring, i, lv);

        // Walk the longer row; the shorter one advances when it is reached.
        if (n_cur > n_prev) begin
            n_long = n_cur; n_short = n_prev; lrow = cur_row; srow = prev_row;
            ord = wind_cw;
        end else begin
            n_long = n_prev; n_short = n_cur; lrow = prev_row; srow = cur_row;
            ord = !wind_cw;
        end
        n_steps = n_long - 1;
        si = 0;
        for (int i = 0; i < n_steps; i++) begin
            if (longint'(lrow[i].pn) * srow[si].pd >= longint'(srow[si].pn) * lrow[i].pd
                    && si + 1 < n_short) begin
                if (ord) band.push_back(make_tri(side, side, side,
                                                 srow[si], lrow[i], srow[si+1]));
                else     band.push_back(make_tri(side, side, side,
                                                 srow[si], srow[si+1], lrow[i]));
                si++;
            end
            if (ord) band.push_back(make_tri(side, side, side, lrow[i], lrow[i+1], srow[si]));
            else     band.push_back(make_tri(side, side, side, lrow[i], srow[si], lrow[i+1]));
        end
        if (si + 1 != n_short) begin
            if (ord) band.push_back(make_tri(side, side, side,
                                             srow[si], lrow[n_steps], srow[si+1]));
            else     band.push_back(make_tri(side, side, side,
                                             srow[si], srow[si+1], lrow[n_steps]));
        end

        // Odd inner level: side 2's innermost band closes with the centre.
        if (side == 2 && ring + 1 == lv / 2 && n_cur == 2) begin
            band.push_back(make_tri(0, wind_cw ? 2 : 1, wind_cw ? 1 : 2,
                                    ring_vtx(ring, 0, lv), ring_vtx(ring, 0, lv),
                                    ring_vtx(ring, 0, lv)));
        end
        band[band.size() - 1].last_of_band = 1'b1;
        foreach (band[j]) tri_queue.push_back(band[j]);
    endfunction

    // Offer one item and return at the edge where it is taken.
    task automatic send_item(tpb_pkg::t_in req);
        predict_band(req);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in <= req;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_band(int side, int ring);
        tpb_pkg::t_in req;
        req.side_index = 2'(side);
        req.ring_index = 4'(ring);
        send_item(req);
    endtask

    // Lower valid and wait until every expected triangle has been taken.
    task automatic drain;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tri_queue.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, int val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 6'(val);
        case (idx)
            tpb_pkg::REG_OUTER0:    lvl_outer[0] = val & 63;
            tpb_pkg::REG_OUTER1:    lvl_outer[1] = val & 63;
            tpb_pkg::REG_OUTER2:    lvl_outer[2] = val & 63;
            tpb_pkg::REG_INNER:     lvl_inner = val & 63;
            tpb_pkg::REG_CLOCKWISE: wind_cw = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic write_levels(int o0, int o1, int o2, int inner, int cw);
        write_reg(tpb_pkg::REG_OUTER0, o0);
        write_reg(tpb_pkg::REG_OUTER1, o1);
        write_reg(tpb_pkg::REG_OUTER2, o2);
        write_reg(tpb_pkg::REG_INNER, inner);
        write_reg(tpb_pkg::REG_CLOCKWISE, cw);
    endtask

    // Reset levels: one ring, every side, plus out of range requests.
    task automatic test_reset_levels;
        send_band(tpb_pkg::SIDE_0, 0);
        send_band(tpb_pkg::SIDE_1, 0);
        send_band(tpb_pkg::SIDE_2, 0);
        send_band(tpb_pkg::SIDE_3, 0);
        send_band(tpb_pkg::SIDE_0, 1);
        drain();
    endtask

    // Extremes of the levels, the centre triangle, clamping and winding.
    task automatic test_directed;
        write_levels(32, 32, 32, 32, 0);
        send_band(tpb_pkg::SIDE_0, 0);
        send_band(tpb_pkg::SIDE_2, 15);
        send_band(tpb_pkg::SIDE_1, 15);
        drain();
        write_levels(1, 5, 32, 3, 1);
        send_band(tpb_pkg::SIDE_0, 0);
        send_band(tpb_pkg::SIDE_1, 0);
        send_band(tpb_pkg::SIDE_2, 0);
        send_band(tpb_pkg::SIDE_2, 1);
        drain();
        write_levels(0, 63, 4, 7, 0);
        send_band(tpb_pkg::SIDE_0, 0);
        send_band(tpb_pkg::SIDE_1, 0);
        send_band(tpb_pkg::SIDE_2, 2);
        send_band(tpb_pkg::SIDE_1, 2);
        send_band(tpb_pkg::SIDE_3, 15);
        drain();
        // A write past the register list leaves the levels alone.
        write_reg(REG_UNUSED, 63);
        write_levels(3, 2, 7, 2, 1);
        send_band(tpb_pkg::SIDE_0, 0);
        send_band(tpb_pkg::SIDE_2, 0);
        send_band(tpb_pkg::SIDE_1, 8);
        drain();
    endtask

    // Random bands under one idling setting; mostly small levels.
    task automatic test_random_phase(int idle_pct, int stall_pct, int n_items);
        int lv;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        if ($urandom_range(3) == 0) begin
            write_levels($urandom_range(1, 32), $urandom_range(1, 32),
                         $urandom_range(1, 32), $urandom_range(2, 32), $urandom_range(1));
        end else begin
            write_levels($urandom_range(1, 6), $urandom_range(1, 6),
                         $urandom_range(1, 6), $urandom_range(2, 9), $urandom_range(1));
        end
        lv = clamp_lvl(lvl_inner, 2);
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(9) < 8) send_band($urandom_range(2), $urandom_range(lv / 2 - 1));
            else                       send_band($urandom_range(3), $urandom_range(15));
        end
        drain();
    endtask

    // Long receiver hold-off while requests keep coming.
    task automatic test_backpressure;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_levels(2, 3, 4, 5, 0);
        hold_cycles = 600;
        for (int n = 0; n < 8; n++) send_band($urandom_range(3), $urandom_range(15));
        drain();
    endtask

    // Receiver side: random stalls, or a held stretch when asked.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic cmp_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    // Compare each taken triangle with the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (tri_queue.size() == 0) begin
                $error("unexpected result item");
                fail_cnt++;
            end else begin
                tpb_pkg::t_out e;
                e = tri_queue.pop_front();
                cmp_field("first_x", e.first_x, o_out.first_x);
                cmp_field("first_y", e.first_y, o_out.first_y);
                cmp_field("first_z", e.first_z, o_out.first_z);
                cmp_field("second_x", e.second_x, o_out.second_x);
                cmp_field("second_y", e.second_y, o_out.second_y);
                cmp_field("second_z", e.second_z, o_out.second_z);
                cmp_field("third_x", e.third_x, o_out.third_x);
                cmp_field("third_y", e.third_y, o_out.third_y);
                cmp_field("third_z", e.third_z, o_out.third_z);
                cmp_field("empty_band", e.empty_band, o_out.empty_band);
                cmp_field("last_of_band", e.last_of_band, o_out.last_of_band);
            end
        end
    end

    initial begin
        lvl_outer[0] = 1;
        lvl_outer[1] = 1;
        lvl_outer[2] = 1;
        lvl_inner = 2;
        wind_cw = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_levels();
        test_directed();
        test_random_phase(0, 0, 20);
        test_random_phase(56, 0, 20);
        test_random_phase(0, 56, 20);
        test_random_phase(6, 6, 20);
        test_backpressure();
        if (fail_cnt == 0 && tri_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
